/* src/wsd_pkg.sv */
package wsd_pkg;

  localparam int FIELD_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIX  = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

endpackage

/* src/wsd_ctrl.sv */
module wsd_ctrl #(
  parameter int WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output wsd_pkg::cmd_t cmd
);

  localparam int CW = $clog2(WIDTH);

  wsd_pkg::state_t state;
  wsd_pkg::state_t state_next;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   cnt_next;

  assign busy = (state != wsd_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      wsd_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = wsd_pkg::ST_DIV;
        end
      end
      wsd_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          state_next = wsd_pkg::ST_FIX;
        end
      end
      wsd_pkg::ST_FIX: begin
        cmd.finish = 1'b1;
        state_next = wsd_pkg::ST_IDLE;
      end
      default: begin
        state_next = wsd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsd_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

/* src/wsd_dp.sv */
module wsd_dp #(
  parameter int WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wsd_pkg::cmd_t                     cmd,
  input  logic signed [wsd_pkg::FIELD_W-1:0] dividend,
  input  logic signed [wsd_pkg::FIELD_W-1:0] divisor,
  output logic                              done,
  output logic signed [wsd_pkg::FIELD_W-1:0] quotient,
  output logic signed [wsd_pkg::FIELD_W-1:0] remainder,
  output logic                              remainder_nonzero,
  output logic                              divide_by_zero
);

  localparam int FW = wsd_pkg::FIELD_W;

  logic [WIDTH-1:0] a_in;
  logic [WIDTH-1:0] b_in;
  logic [WIDTH-1:0] a_mag;
  logic [WIDTH-1:0] b_mag;

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] qreg;
  logic [WIDTH-1:0] breg;
  logic             neg_q;
  logic             neg_r;
  logic             dz;

  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] q_fix;
  logic [WIDTH-1:0] r_fix;

  assign a_in  = dividend[WIDTH-1:0];
  assign b_in  = divisor[WIDTH-1:0];
  assign a_mag = a_in[WIDTH-1] ? (~a_in + WIDTH'(1)) : a_in;
  assign b_mag = b_in[WIDTH-1] ? (~b_in + WIDTH'(1)) : b_in;

  // trial subtract of the shifted partial remainder
  assign diff  = {acc, qreg[WIDTH-1]} - {1'b0, breg};

  assign q_fix = dz ? '0 : (neg_q ? (~qreg + WIDTH'(1)) : qreg);
  assign r_fix = dz ? '0 : (neg_r ? (~acc + WIDTH'(1)) : acc);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc   <= '0;
      qreg  <= a_mag;
      breg  <= b_mag;
      neg_q <= a_in[WIDTH-1] ^ b_in[WIDTH-1];
      neg_r <= a_in[WIDTH-1];
      dz    <= (b_in == '0);
    end else if (cmd.step) begin
      if (!diff[WIDTH]) begin
        acc <= diff[WIDTH-1:0];
      end else begin
        acc <= {acc[WIDTH-2:0], qreg[WIDTH-1]};
      end
      qreg <= {qreg[WIDTH-2:0], ~diff[WIDTH]};
    end
    if (cmd.finish) begin
      quotient          <= FW'(signed'(q_fix));
      remainder         <= FW'(signed'(r_fix));
      remainder_nonzero <= (r_fix != '0);
      divide_by_zero    <= dz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

/* src/wide_signed_divider_unit.sv */
// channel   ports                                         handshake
// input     dividend, divisor                             start, busy
// result    quotient, remainder, remainder_nonzero,       done (one-cycle strobe)
//           divide_by_zero
//
// done rises with the registered result: the accepting edge loads the sign
// magnitudes, then WIDTH restoring steps run, then a sign fix-up state;
// the radix-2 step loop sets the pace, and no new item is taken while busy
// busy is high from the accepting edge until the result is registered
// a new item may be started in the cycle that done is high
// reset is synchronous and returns the controller to idle with done low
// results cannot be held off by the receiver
module wide_signed_divider_unit #(
  parameter int WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [wsd_pkg::FIELD_W-1:0] dividend,
  input  logic signed [wsd_pkg::FIELD_W-1:0] divisor,
  output logic                              done,
  output logic signed [wsd_pkg::FIELD_W-1:0] quotient,
  output logic signed [wsd_pkg::FIELD_W-1:0] remainder,
  output logic                              remainder_nonzero,
  output logic                              divide_by_zero
);

  wsd_pkg::cmd_t cmd;

  wsd_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  wsd_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .dividend         (dividend),
    .divisor          (divisor),
    .done             (done),
    .quotient         (quotient),
    .remainder        (remainder),
    .remainder_nonzero(remainder_nonzero),
    .divide_by_zero   (divide_by_zero)
  );

endmodule

/* src/wsd_checker.sv */
module wsd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [wsd_pkg::FIELD_W-1:0] quotient,
  input logic signed [wsd_pkg::FIELD_W-1:0] remainder,
  input logic                              remainder_nonzero,
  input logic                              divide_by_zero
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not raise busy");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (quotient == '0 && remainder == '0 && !remainder_nonzero))
    else $error("zero divisor result not zero");

  a_rem_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder_nonzero == (remainder != '0)))
    else $error("remainder flag mismatch");

endmodule

bind wide_signed_divider_unit wsd_checker u_wsd_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .quotient         (quotient),
  .remainder        (remainder),
  .remainder_nonzero(remainder_nonzero),
  .divide_by_zero   (divide_by_zero)
);
